// File: sv/pcn_pkg.sv
// Package: shared types, constants and the calendar month table.
`default_nettype none
package pcn_pkg;

  // Action codes carried on the input word.
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [11:0] BASE_YEAR    = 12'd1900;
  // Leap years counted through the year before the base year.
  localparam logic [31:0] LEAPS_BASE   = 32'd460;
  // floor(n / 100) == (n * RECIP_100) >> RECIP_SHIFT for every 12-bit n.
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_SHIFT  = 19;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [31:0] DAYS_PER_YR  = 32'd365;
  localparam logic [3:0]  LAST_MONTH   = 4'd12;
  localparam logic [3:0]  LEAP_MONTH   = 4'd2;

  localparam int DIV_BITS = 32;
  localparam int CNT_W    = $clog2(DIV_BITS);

  typedef struct packed {
    logic load_upd;
    logic load_qry;
    logic div_step;
    logic mul;
    logic ep1;
    logic ep2;
    logic ep3;
    logic out_load;
  } pcn_cmd_t;

  typedef struct packed {
    logic est_zero;
  } pcn_sts_t;

  // Days in the whole months before month m (m already clamped to 0..12).
  function automatic logic [8:0] month_cum(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd334;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: sv/pcn_ctrl.sv
// Controller: sequencer for update, divide, multiply, epoch steps and result hand-off.
`default_nettype none
module pcn_ctrl
  import pcn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     action,
  input  wire logic     out_ready,
  input  wire pcn_sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output pcn_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_EP1  = 3'd3;
  localparam logic [2:0] S_EP2  = 3'd4;
  localparam logic [2:0] S_EP3  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load_upd = accept && (action == ACT_UPDATE);
    cmd.load_qry = accept && (action == ACT_QUERY);
    cmd.div_step = (state == S_DIV);
    cmd.mul      = (state == S_MUL);
    cmd.ep1      = (state == S_EP1);
    cmd.ep2      = (state == S_EP2);
    cmd.ep3      = (state == S_EP3);
    cmd.out_load = (state == S_DONE) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_QUERY && !sts.est_zero) state_next = S_DIV;
          else state_next = S_EP1;
        end
      end
      S_DIV: begin
        if (&cnt) state_next = S_MUL;
      end
      S_MUL:  state_next = S_EP1;
      S_EP1:  state_next = S_EP2;
      S_EP2:  state_next = S_EP3;
      S_EP3:  state_next = S_DONE;
      S_DONE: begin
        if (cmd.out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_qry) cnt <= '0;
      else if (cmd.div_step) cnt <= cnt + 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: sv/pcn_dp.sv
// Datapath: time state, shared radix-2 divider, epoch arithmetic, result registers.
`default_nettype none
module pcn_dp
  import pcn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pcn_cmd_t    cmd,
  input  wire logic [31:0] now_ms,
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hours,
  input  wire logic [5:0]  minutes,
  input  wire logic [5:0]  seconds,
  output pcn_sts_t         sts,
  output logic [31:0]      epoch_seconds,
  output logic [31:0]      fraction,
  output logic             fraction_valid
);

  // Time state
  logic [11:0] st_year;
  logic [3:0]  st_month;
  logic [4:0]  st_day;
  logic [4:0]  st_hours;
  logic [5:0]  st_minutes;
  logic [5:0]  st_seconds;
  logic [31:0] est, last_ms;
  logic [31:0] est_next, elapsed;

  // Divider: remainder of elapsed, quotient of all-ones, same divisor
  logic [31:0] a_sh, r_a, r_b, q_b;
  logic [32:0] ta, tb;
  logic        ge_a, ge_b;

  // Working result
  logic [31:0] frac_w;
  logic        fvalid_w;
  logic [63:0] prod;

  // Epoch steps
  logic [11:0] ym1;
  logic [24:0] pm, py;
  logic [5:0]  q100m, q100y;
  logic [31:0] days, epoch_w;
  logic [16:0] tod;
  logic [31:0] days_next, leaps, dy32, cum32;
  logic [16:0] tod_next;
  logic [3:0]  m_cl;
  logic        leap_yr;
  logic [12:0] dy;
  logic [48:0] ep_prod;

  assign sts.est_zero = (est == '0);
  assign elapsed      = now_ms - last_ms;
  assign est_next     = (est + elapsed) >> 1;

  assign ta   = {r_a, a_sh[31]};
  assign tb   = {r_b, 1'b1};
  assign ge_a = (ta >= {1'b0, est});
  assign ge_b = (tb >= {1'b0, est});
  assign prod = r_a * q_b;

  // Reciprocal divides by 100
  assign ym1 = st_year - 12'd1;
  assign pm  = ym1 * RECIP_100;
  assign py  = st_year * RECIP_100;

  always_comb begin
    m_cl    = (st_month > LAST_MONTH) ? LAST_MONTH : st_month;
    leap_yr = (st_year[1:0] == 2'b00) &&
              ((st_year != ({6'b0, q100y} * 12'd100)) || (q100y[1:0] == 2'b00));
    leaps   = '0;
    if (st_year > BASE_YEAR) begin
      leaps = 32'(ym1 >> 2) - 32'(q100m) + 32'(q100m >> 2) - LEAPS_BASE;
    end
    dy        = {1'b0, st_year} - {1'b0, BASE_YEAR};
    dy32      = {{19{dy[12]}}, dy};
    cum32     = 32'(month_cum(m_cl));
    days_next = leaps + 32'(dy32 * DAYS_PER_YR) + cum32 + 32'(st_day) - 32'd1
              + 32'(leap_yr && (m_cl > LEAP_MONTH));
    tod_next  = 17'(st_hours) * 17'd3600 + 17'(st_minutes) * 17'd60 + 17'(st_seconds);
  end

  assign ep_prod = days * SECS_PER_DAY;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_year    <= '0;
      st_month   <= '0;
      st_day     <= '0;
      st_hours   <= '0;
      st_minutes <= '0;
      st_seconds <= '0;
      est        <= '0;
      last_ms    <= '0;
    end else if (cmd.load_upd) begin
      st_year    <= year;
      st_month   <= month;
      st_day     <= day;
      st_hours   <= hours;
      st_minutes <= minutes;
      st_seconds <= seconds;
      est        <= est_next;
      last_ms    <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_upd) begin
      frac_w   <= '0;
      fvalid_w <= (est_next != '0);
    end
    if (cmd.load_qry) begin
      frac_w   <= '0;
      fvalid_w <= !sts.est_zero;
      a_sh     <= elapsed;
      r_a      <= '0;
      r_b      <= '0;
      q_b      <= '0;
    end
    if (cmd.div_step) begin
      a_sh <= {a_sh[30:0], 1'b0};
      r_a  <= ge_a ? 32'(ta - {1'b0, est}) : ta[31:0];
      r_b  <= ge_b ? 32'(tb - {1'b0, est}) : tb[31:0];
      q_b  <= {q_b[30:0], ge_b};
    end
    if (cmd.mul) frac_w <= prod[31:0];
    if (cmd.ep1) begin
      q100m <= pm[RECIP_SHIFT +: 6];
      q100y <= py[RECIP_SHIFT +: 6];
    end
    if (cmd.ep2) begin
      days <= days_next;
      tod  <= tod_next;
    end
    if (cmd.ep3) epoch_w <= ep_prod[31:0] + 32'(tod);
    if (cmd.out_load) begin
      epoch_seconds  <= epoch_w;
      fraction       <= frac_w;
      fraction_valid <= fvalid_w;
    end
  end

endmodule
`default_nettype wire

// File: sv/pps_calendar_ntp_timestamp.sv
// Top level: NTP timestamp from receiver calendar updates and a millisecond counter.
//
//  channel | handshake           | word
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_ready | action, now_ms, year, month, day, hours,
//          |                     | minutes, seconds
//  out     | out_valid/out_ready | epoch_seconds, fraction, fraction_valid
//
// Sequence: an update runs three epoch arithmetic steps and a hand-off
//   after acceptance; a query with a nonzero estimate first runs the
//   radix-2 divider (one bit a cycle, 32 bits) and its following multiply.
//   A query with a zero estimate runs the same steps as an update.
// One word is worked on at a time; in_ready rises again once the result
//   is placed in the output register, even while that register still waits.
// Reset (synchronous) clears the stored date, estimate and last counter
//   value to zero and empties the output register.
// A stall on out holds the finished word in the working registers, with the
//   sequencer waiting in its done state until the output register frees up.
`default_nettype none
module pps_calendar_ntp_timestamp
  import pcn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [31:0] now_ms,
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hours,
  input  wire logic [5:0]  minutes,
  input  wire logic [5:0]  seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      epoch_seconds,
  output logic [31:0]      fraction,
  output logic             fraction_valid
);

  pcn_cmd_t cmd;
  pcn_sts_t sts;

  // Sequence the word: load, divide, multiply, epoch steps, hand off
  pcn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Hold time state, run the arithmetic, drive the result word
  pcn_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .now_ms         (now_ms),
    .year           (year),
    .month          (month),
    .day            (day),
    .hours          (hours),
    .minutes        (minutes),
    .seconds        (seconds),
    .sts            (sts),
    .epoch_seconds  (epoch_seconds),
    .fraction       (fraction),
    .fraction_valid (fraction_valid)
  );

endmodule
`default_nettype wire

// File: sv/pcn_checker.sv
// Checker: port-level properties of the timestamp block, bound to the top level.
`default_nettype none
module pcn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] epoch_seconds,
  input wire logic [31:0] fraction,
  input wire logic        fraction_valid
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(epoch_seconds) &&
      $stable(fraction) && $stable(fraction_valid))
    else $error("result word changed while stalled");

  // No fraction without an estimate
  a_frac_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fraction_valid |-> fraction == 32'd0)
    else $error("fraction nonzero while flagged invalid");

  // One word at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // Output register empty after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind pps_calendar_ntp_timestamp pcn_checker u_pcn_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .epoch_seconds  (epoch_seconds),
  .fraction       (fraction),
  .fraction_valid (fraction_valid)
);
`default_nettype wire

// File: bench/pps_calendar_ntp_timestamp_test.sv
// Self-checking bench for the calendar plus millisecond counter NTP timestamp unit.
`default_nettype none
module pps_calendar_ntp_timestamp_test
  import pcn_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Date-time carried by an update word, in port order.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } calendar_t;

  // One input word.
  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    calendar_t   date;
  } word_t;

  // One output word: the timestamp.
  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic [31:0] fraction;
    logic        fraction_valid;
  } stamp_t;

  // Block ports; every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_UPDATE;
  logic [31:0] now_ms = '0;
  logic [11:0] year = '0;
  logic [3:0]  month = '0;
  logic [4:0]  day = '0;
  logic [4:0]  hours = '0;
  logic [5:0]  minutes = '0;
  logic [5:0]  seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] epoch_seconds;
  logic [31:0] fraction;
  logic        fraction_valid;

  // Timestamps owed by the block, oldest first.
  stamp_t pending_stamps[$];

  // Our own copy of the block's state, cleared as by reset.
  calendar_t   held_date = '0;
  logic [31:0] ms_per_sec = '0;
  logic [31:0] last_tick = '0;

  // Idling knobs and the long output hold-off request.
  bit          sender_idle = 1'b1;
  bit          receiver_idle = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  // Run statistics.
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned updates_sent = 0;
  int unsigned stamps_seen = 0;
  int unsigned flagless_seen = 0;
  int unsigned in_stall_cycles = 0;

  pps_calendar_ntp_timestamp DUT (.*);

  always #5 clk = ~clk;

  // Give up long after the slowest correct run would have ended.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic, all modulo 2^32 as the block keeps it.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] month_length(input logic [31:0] m);
    case (m)
      32'd2:                      return 32'd28;
      32'd4, 32'd6, 32'd9, 32'd11: return 32'd30;
      default:                    return 32'd31;
    endcase
  endfunction

  function automatic logic is_leap_year(input logic [31:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Leap years in 1..n.
  function automatic logic [31:0] leap_count(input logic [31:0] n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Seconds since the start of 1900 for a stored date; out-of-range fields
  // count linearly, months past twelve clamp to twelve.
  function automatic logic [31:0] ntp_seconds(input calendar_t c);
    logic [31:0] y;
    logic [31:0] m;
    logic [31:0] secs;
    logic [31:0] days;
    logic [31:0] i;
    y    = 32'(c.year);
    m    = (c.month > LAST_MONTH) ? 32'(LAST_MONTH) : 32'(c.month);
    secs = 32'(c.seconds) + 32'(c.minutes) * 32'd60 + 32'(c.hours) * 32'd3600;
    days = '0;
    // Years before the base count no leap days at all.
    if (y > 32'(BASE_YEAR))
      days = leap_count(y - 32'd1) - leap_count(32'(BASE_YEAR) - 32'd1);
    days = days + 32'd365 * (y - 32'(BASE_YEAR));
    for (i = 32'd1; i < m; i++)
      days = days + month_length(i);
    // Day zero wraps to one day back.
    days = days + 32'(c.day) - 32'd1;
    if (is_leap_year(y) && m > 32'(LEAP_MONTH))
      days = days + 32'd1;
    return secs + days * 32'd86400;
  endfunction

  // Advance our state by one accepted word and work out its timestamp.
  task automatic stamp_for(input word_t w, output stamp_t r);
    logic [31:0] elapsed;
    elapsed    = w.now_ms - last_tick;
    r.fraction = '0;
    if (w.action == ACT_UPDATE) begin
      held_date        = w.date;
      // Sum wraps before halving.
      ms_per_sec       = (ms_per_sec + elapsed) / 32'd2;
      last_tick        = w.now_ms;
      r.fraction_valid = (ms_per_sec != 0);
    end else if (ms_per_sec != 0) begin
      r.fraction       = (elapsed % ms_per_sec) * (32'hFFFF_FFFF / ms_per_sec);
      r.fraction_valid = 1'b1;
    end else begin
      // No estimate yet: no fraction, flag low.
      r.fraction_valid = 1'b0;
    end
    r.epoch_seconds = ntp_seconds(held_date);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A real calendar date as a receiver would report it, leap second now and then.
  function automatic calendar_t legal_date();
    calendar_t   c;
    int unsigned dim;
    c.year    = 12'($urandom_range(1900, 2099));
    c.month   = 4'($urandom_range(1, 12));
    dim       = month_length(32'(c.month));
    if (c.month == LEAP_MONTH && is_leap_year(32'(c.year)))
      dim++;
    c.day     = 5'($urandom_range(1, dim));
    c.hours   = 5'($urandom_range(0, 23));
    c.minutes = 6'($urandom_range(0, 59));
    c.seconds = ($urandom_range(0, 49) == 0) ? 6'd60 : 6'($urandom_range(0, 59));
    return c;
  endfunction

  // Any bit pattern the fields can carry.
  function automatic calendar_t any_date();
    calendar_t c;
    c.year    = 12'($urandom());
    c.month   = 4'($urandom());
    c.day     = 5'($urandom());
    c.hours   = 5'($urandom());
    c.minutes = 6'($urandom());
    c.seconds = 6'($urandom());
    return c;
  endfunction

  // Offer one word from a falling edge, wait for the handshake, log the
  // expected timestamp and return on the next falling edge. Valid stays
  // high on return; the next call either replaces the word or drops it.
  task automatic send_word(input word_t w);
    int unsigned gap;
    stamp_t      r;
    gap = sender_idle ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action   <= w.action;
    now_ms   <= w.now_ms;
    year     <= w.date.year;
    month    <= w.date.month;
    day      <= w.date.day;
    hours    <= w.date.hours;
    minutes  <= w.date.minutes;
    seconds  <= w.date.seconds;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      in_stall_cycles++;
      @(posedge clk);
    end
    stamp_for(w, r);
    pending_stamps.push_back(r);
    words_sent++;
    if (w.action == ACT_UPDATE)
      updates_sent++;
    @(negedge clk);
  endtask

  task automatic send_update(input int unsigned y, input int unsigned mo, input int unsigned d,
                             input int unsigned h, input int unsigned mi, input int unsigned s,
                             input logic [31:0] tick);
    word_t w;
    w.action       = ACT_UPDATE;
    w.now_ms       = tick;
    w.date.year    = 12'(y);
    w.date.month   = 4'(mo);
    w.date.day     = 5'(d);
    w.date.hours   = 5'(h);
    w.date.minutes = 6'(mi);
    w.date.seconds = 6'(s);
    send_word(w);
  endtask

  // Date fields of a query carry rubbish: the block must ignore them.
  task automatic send_query(input logic [31:0] tick);
    word_t w;
    w.action = ACT_QUERY;
    w.now_ms = tick;
    w.date   = any_date();
    send_word(w);
  endtask

  // Drop valid and wait until every owed timestamp has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_stamps.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Field extremes, both actions and the calendar corner cases.
  task automatic test_directed_cases();
    // Straight after reset: all-zero date and no estimate, so no fraction.
    send_query(32'd0);
    send_query(32'hFFFF_FFFF);
    send_update(1900, 1, 1, 0, 0, 0, 32'd1000);
    send_query(32'd1250);
    // Counter behind the last update: elapsed wraps.
    send_query(32'd999);
    send_update(2099, 12, 31, 23, 59, 60, 32'd2000);
    // Leap day rules: divisible by 400, by 100 only, by 4.
    send_update(2000, 3, 1, 0, 0, 0, 32'd3000);
    send_update(1900, 3, 1, 0, 0, 0, 32'd4000);
    send_update(2100, 3, 1, 0, 0, 0, 32'd5000);
    send_update(2024, 2, 29, 12, 30, 30, 32'd6000);
    // Years before the base wrap the year product; year zero, month zero, day zero.
    send_update(1899, 6, 15, 8, 0, 0, 32'd7000);
    send_update(0, 0, 0, 0, 0, 0, 32'd8000);
    // Every field at its all-ones value; month past twelve clamps.
    send_update(4095, 15, 31, 31, 63, 63, 32'd9000);
    send_update(2023, 13, 1, 0, 0, 0, 32'd10000);
    send_query(32'd10777);
    // Pull the estimate back to zero, then ask for a fraction.
    send_update(2030, 7, 4, 1, 2, 3, last_tick - ms_per_sec);
    send_query(last_tick + 32'd123);
    // Near-full elapsed time, then a wrapping sum that leaves an estimate of one.
    send_update(2031, 1, 1, 0, 0, 0, last_tick + 32'hFFFF_FFFE);
    send_update(2031, 1, 1, 0, 0, 1, last_tick + 32'h8000_0004);
    send_query(last_tick + 32'd77);
    send_update(2031, 1, 1, 0, 0, 2, last_tick + 32'd1000);
    send_query(32'hFFFF_FFFF);
    settle();
  endtask

  // Updates about once a second with real dates, each followed by a few
  // queries; now and then the counter jumps, misses a pulse or wraps.
  task automatic test_pps_updates(input int unsigned n);
    word_t       w;
    logic [31:0] tick;
    int unsigned sent;
    int unsigned k;
    int unsigned extra;
    tick = $urandom();
    sent = 0;
    while (sent < n) begin
      w.action = ACT_UPDATE;
      w.now_ms = tick;
      w.date   = legal_date();
      send_word(w);
      sent++;
      extra = $urandom_range(0, 4);
      for (k = 0; k < extra && sent < n; k++) begin
        send_query(tick + $urandom_range(0, 1100));
        sent++;
      end
      case ($urandom_range(0, 19))
        0:       tick = tick + $urandom();
        1:       tick = 32'hFFFF_FFFF - $urandom_range(0, 1500);
        2:       tick = tick + 32'd2000 + $urandom_range(0, 40);
        default: tick = tick + 32'd975 + $urandom_range(0, 50);
      endcase
    end
    settle();
  endtask

  // Broken streams: random actions, random counter values, any field bits.
  task automatic test_noise(input int unsigned n);
    word_t       w;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      w.action = ($urandom_range(0, 1) == 0) ? ACT_UPDATE : ACT_QUERY;
      w.now_ms = ($urandom_range(0, 1) == 0) ? 32'($urandom())
                                             : last_tick + $urandom_range(0, 3000);
      w.date   = ($urandom_range(0, 2) == 0) ? legal_date() : any_date();
      send_word(w);
    end
    settle();
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // block fills and stops taking input.
  task automatic test_output_hold();
    word_t       w;
    int unsigned i;
    sender_idle = 1'b0;
    hold_req    = 300;
    for (i = 0; i < 30; i++) begin
      w.action = ($urandom_range(0, 2) == 0) ? ACT_UPDATE : ACT_QUERY;
      w.now_ms = last_tick + $urandom_range(500, 1500);
      w.date   = (w.action == ACT_UPDATE) ? legal_date() : any_date();
      send_word(w);
    end
    sender_idle = 1'b1;
    settle();
  endtask

  // A stretch with no gaps on either side.
  task automatic test_back_to_back(input int unsigned n);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    test_pps_updates(n);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off counted here in cycles.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = idle_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each timestamp with the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stamp_t owed;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      stamps_seen++;
      if (fraction_valid === 1'b0)
        flagless_seen++;
      if (pending_stamps.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected word epoch %h fraction %h valid %b",
                   $time, epoch_seconds, fraction, fraction_valid);
      end else begin
        owed = pending_stamps.pop_front();
        if (epoch_seconds !== owed.epoch_seconds || fraction !== owed.fraction ||
            fraction_valid !== owed.fraction_valid) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch epoch %h/%h fraction %h/%h valid %b/%b (exp/got)",
                     $time, owed.epoch_seconds, epoch_seconds, owed.fraction, fraction,
                     owed.fraction_valid, fraction_valid);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests.
  // ---------------------------------------------------------------------------
  initial begin
    // Hold reset, release on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_pps_updates(490);
    test_noise(150);
    test_output_hold();
    test_back_to_back(60);

    // Let any stray word surface before the verdict.
    settle();
    repeat (60) @(posedge clk);
    fail_count += pending_stamps.size();

    $display("Run covered %0d words (%0d updates, %0d queries); %0d stamps had no fraction.",
             words_sent, updates_sent, words_sent - updates_sent, flagless_seen);
    $display("Input was held back for %0d cycles; %0d stamps checked, %0d faults.",
             in_stall_cycles, stamps_seen, fail_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

// File: pps_calendar_ntp_timestamp.f
sv/pcn_pkg.sv
sv/pcn_ctrl.sv
sv/pcn_dp.sv
sv/pps_calendar_ntp_timestamp.sv
sv/pcn_checker.sv
bench/pps_calendar_ntp_timestamp_test.sv
